@@ design/pkgrad_pkg.sv @@
// Shared types, constants and small tables for the periodic kernel block.
// No dependencies; used by pkgrad_alu, pkgrad_seq and the top level.
`timescale 1ns / 1ps

package pkgrad_pkg;

  localparam int ELEM_W = 16;
  localparam int ACC_W  = 48;

  localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] ONE_Q30   = 64'h0000_0000_4000_0000;
  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] EXP_LIMIT = 64'h0000_0020_0000_0000;
  localparam logic [63:0] E_BIG     = 64'h2000_0000_0000_0000;
  localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [1:0] MUL_LAST  = 2'd3;

  localparam logic [3:0] SC_TERMS  = 4'd7;
  localparam logic [3:0] EXP_TERMS = 4'd13;
  localparam logic [3:0] SQ_LAST   = 4'd4;
  localparam logic [1:0] QDIV_LAST = 2'd3;

  localparam logic CFG_LENGTH = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic        valid;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  sh;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] y;
    logic [63:0] r;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_MULF,
    A_DIV,
    A_SQRT
  } alu_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQRT,
    S_DMOD,
    S_FRAC,
    S_ANG,
    S_X2,
    S_SMUL,
    S_SDIV,
    S_CMUL,
    S_CDIV,
    S_S2,
    S_E0,
    S_E1,
    S_TMUL,
    S_TDIV,
    S_KSQ,
    S_LMUL,
    S_LDIV,
    S_PSC,
    S_PK,
    S_PD,
    S_PPI,
    S_QHI,
    S_QLO,
    S_FIN
  } seq_state_t;

  // Taylor term divisors: sin uses (2n)(2n+1), cos uses (2n-1)(2n)
  function automatic logic [7:0] sin_div(input logic [3:0] n);
    case (n)
      4'd1:    sin_div = 8'd6;
      4'd2:    sin_div = 8'd20;
      4'd3:    sin_div = 8'd42;
      4'd4:    sin_div = 8'd72;
      4'd5:    sin_div = 8'd110;
      4'd6:    sin_div = 8'd156;
      4'd7:    sin_div = 8'd210;
      default: sin_div = 8'd1;
    endcase
  endfunction

  function automatic logic [7:0] cos_div(input logic [3:0] n);
    case (n)
      4'd1:    cos_div = 8'd2;
      4'd2:    cos_div = 8'd12;
      4'd3:    cos_div = 8'd30;
      4'd4:    cos_div = 8'd56;
      4'd5:    cos_div = 8'd90;
      4'd6:    cos_div = 8'd132;
      4'd7:    cos_div = 8'd182;
      default: cos_div = 8'd1;
    endcase
  endfunction

  function automatic logic [30:0] clamp30(input logic signed [63:0] v);
    if (v < 0) clamp30 = '0;
    else if (v > $signed(ONE_Q30)) clamp30 = ONE_Q30[30:0];
    else clamp30 = v[30:0];
  endfunction

  function automatic logic [32:0] clamp32(input logic signed [63:0] v);
    if (v < 0) clamp32 = '0;
    else if (v > $signed(ONE_Q32)) clamp32 = ONE_Q32[32:0];
    else clamp32 = v[32:0];
  endfunction

endpackage

@@ design/pkgrad_alu.sv @@
// Shared arithmetic unit: 64x64 multiply with saturating right shift
// (four 32x32 partial products), 64/64 restoring divide, bitwise square root.
// Depends on pkgrad_pkg.
`timescale 1ns / 1ps

module pkgrad_alu
  import pkgrad_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  alu_state_t state, state_next;
  logic [5:0]   cnt;
  logic [63:0]  opa, opb, quo, rem, yreg, rreg;
  logic [5:0]   sh;
  logic [127:0] acc;
  logic [31:0]  root;
  logic         done;
  logic         fin;

  logic [63:0]  pp;
  logic [127:0] pp_sh, shifted;
  logic [64:0]  drs;
  logic         dge;
  logic [63:0]  div_quo_n, div_rem_n;
  logic [63:0]  srs, strial, sq_rem_n;
  logic         sge;
  logic [31:0]  root_n;

  always_comb begin
    case (cnt[1:0])
      2'd0:    pp = opa[31:0] * opb[31:0];
      2'd1:    pp = opa[31:0] * opb[63:32];
      2'd2:    pp = opa[63:32] * opb[31:0];
      default: pp = opa[63:32] * opb[63:32];
    endcase
    case (cnt[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      2'd2:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    shifted = acc >> sh;

    drs       = {rem, quo[63]};
    dge       = drs >= {1'b0, opb};
    div_rem_n = dge ? 64'(drs - {1'b0, opb}) : drs[63:0];
    div_quo_n = {quo[62:0], dge};

    srs      = {rem[61:0], quo[63:62]};
    strial   = {30'd0, root, 2'b01};
    sge      = srs >= strial;
    sq_rem_n = sge ? srs - strial : srs;
    root_n   = {root[30:0], sge};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      A_IDLE: begin
        if (req.valid) begin
          unique case (req.op)
            OP_MUL:  state_next = A_MUL;
            OP_DIV:  state_next = A_DIV;
            default: state_next = A_SQRT;
          endcase
        end
      end
      A_MUL:   if (cnt[1:0] == MUL_LAST) state_next = A_MULF;
      A_MULF:  state_next = A_IDLE;
      A_DIV:   if (cnt == DIV_LAST) state_next = A_IDLE;
      A_SQRT:  if (cnt == SQRT_LAST) state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      A_MULF:  fin = 1'b1;
      A_DIV:   fin = (cnt == DIV_LAST);
      A_SQRT:  fin = (cnt == SQRT_LAST);
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      done  <= fin;
      cnt   <= (state == A_IDLE) ? 6'd0 : cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      A_IDLE: begin
        if (req.valid) begin
          opa  <= req.a;
          opb  <= req.b;
          sh   <= req.sh;
          acc  <= '0;
          rem  <= '0;
          root <= '0;
          quo  <= req.a;
        end
      end
      A_MUL: acc <= acc + pp_sh;
      A_MULF: begin
        yreg <= (|shifted[127:64]) ? '1 : shifted[63:0];
        rreg <= '0;
      end
      A_DIV: begin
        quo <= div_quo_n;
        rem <= div_rem_n;
        if (cnt == DIV_LAST) begin
          yreg <= div_quo_n;
          rreg <= div_rem_n;
        end
      end
      A_SQRT: begin
        quo  <= {quo[61:0], 2'b00};
        rem  <= sq_rem_n;
        root <= root_n;
        if (cnt == SQRT_LAST) begin
          yreg <= {32'd0, root_n};
          rreg <= sq_rem_n;
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.y    = yreg;
  assign rsp.r    = rreg;

endmodule

@@ design/pkgrad_seq.sv @@
// Sequencer for the per-vector finish: distance, phase, sin/cos series,
// exponent, kernel and gradient, all issued to the shared pkgrad_alu.
// Depends on pkgrad_pkg.
`timescale 1ns / 1ps

module pkgrad_seq
  import pkgrad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [ACC_W-1:0]  sum,
  input  logic              ovf,
  input  logic              gsel,
  input  logic [31:0]       lsc,
  input  logic [31:0]       per,
  output logic              busy,
  output alu_req_t          req,
  input  alu_rsp_t          rsp,
  output logic              result_valid,
  output logic [16:0]       kernel,
  output logic [31:0]       grad,
  output logic              sat_out
);

  seq_state_t state, state_next;
  logic              issued;
  logic [ACC_W-1:0]  sum_r;
  logic              ovf_r, gsel_r, qsat;
  logic [31:0]       d, f;
  logic [63:0]       x2, ts, tc, t, e, v, tmp, qrem;
  logic signed [63:0] as_acc, ac_acc, eacc;
  logic [30:0]       s, c;
  logic [32:0]       k;
  logic [3:0]        n;
  logic [1:0]        qcnt;

  logic [31:0] ldiv, pdiv, big, small_d, qdiv;
  logic signed [63:0] yv, as_n, ac_n, eacc_n;
  logic [63:0] g, gq, fin_grad;
  logic        neg, satg;
  seq_state_t  grad_state;

  always_comb begin
    ldiv    = (lsc == 32'd0) ? 32'd1 : lsc;
    pdiv    = (per == 32'd0) ? 32'd1 : per;
    big     = (ldiv > pdiv) ? ldiv : pdiv;
    small_d = (ldiv > pdiv) ? pdiv : ldiv;
    qdiv    = qcnt[1] ? small_d : big;
    yv      = $signed({1'b0, rsp.y[62:0]});
    as_n    = n[0] ? as_acc - yv : as_acc + yv;
    ac_n    = n[0] ? ac_acc - yv : ac_acc + yv;
    eacc_n  = n[0] ? eacc - yv : eacc + yv;
    grad_state = gsel_r ? S_PSC : S_LMUL;
  end

  // gradient sign and range
  always_comb begin
    if (!gsel_r) begin
      g   = v;
      neg = 1'b0;
    end else begin
      g   = qsat ? '1 : {16'd0, v[63:16]};
      neg = (f > NEG_LIMIT[31:0]) && (g != 64'd0);
    end
    satg = 1'b0;
    gq   = g;
    if (neg) begin
      if (g > NEG_LIMIT) begin
        gq   = NEG_LIMIT;
        satg = 1'b1;
      end
      fin_grad = ONE_Q32 - gq;
    end else begin
      if (g > POS_LIMIT) begin
        gq   = POS_LIMIT;
        satg = 1'b1;
      end
      fin_grad = gq;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (go) state_next = S_SQRT;
      S_FIN:   state_next = S_IDLE;
      default: begin
        if (rsp.done) begin
          unique case (state)
            S_SQRT: state_next = S_DMOD;
            S_DMOD: state_next = S_FRAC;
            S_FRAC: state_next = S_ANG;
            S_ANG:  state_next = S_X2;
            S_X2:   state_next = S_SMUL;
            S_SMUL: state_next = S_SDIV;
            S_SDIV: state_next = S_CMUL;
            S_CMUL: state_next = S_CDIV;
            S_CDIV: state_next = (n == SC_TERMS) ? S_S2 : S_SMUL;
            S_S2:   state_next = S_E0;
            S_E0:   state_next = (rsp.y >= E_BIG) ? grad_state : S_E1;
            S_E1:   state_next = (rsp.y >= EXP_LIMIT) ? grad_state : S_TMUL;
            S_TMUL: state_next = S_TDIV;
            S_TDIV: state_next = (n == EXP_TERMS) ? S_KSQ : S_TMUL;
            S_KSQ:  state_next = (n == SQ_LAST) ? grad_state : S_KSQ;
            S_LMUL: state_next = S_LDIV;
            S_LDIV: state_next = S_FIN;
            S_PSC:  state_next = S_PK;
            S_PK:   state_next = S_PD;
            S_PD:   state_next = S_PPI;
            S_PPI:  state_next = S_QHI;
            S_QHI:  state_next = (rsp.y[63:48] != 16'd0) ? S_FIN : S_QLO;
            S_QLO:  state_next = (qcnt == QDIV_LAST) ? S_FIN : S_QHI;
            default: state_next = S_IDLE;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    req.valid = !issued && (state != S_IDLE) && (state != S_FIN);
    req.op    = OP_MUL;
    req.a     = '0;
    req.b     = '0;
    req.sh    = 6'd32;
    unique case (state)
      S_SQRT: begin
        req.op = OP_SQRT;
        req.a  = {sum_r, 16'd0};
      end
      S_DMOD: begin
        req.op = OP_DIV;
        req.a  = {32'd0, d};
        req.b  = {32'd0, pdiv};
      end
      S_FRAC: begin
        req.op = OP_DIV;
        req.a  = {tmp[31:0], 32'd0};
        req.b  = {32'd0, pdiv};
      end
      S_ANG: begin
        req.a = tmp;
        req.b = PI_Q30;
      end
      S_X2: begin
        req.a  = ts;
        req.b  = ts;
        req.sh = 6'd30;
      end
      S_SMUL: begin
        req.a  = ts;
        req.b  = x2;
        req.sh = 6'd30;
      end
      S_SDIV: begin
        req.op = OP_DIV;
        req.a  = tmp;
        req.b  = {56'd0, sin_div(n)};
      end
      S_CMUL: begin
        req.a  = tc;
        req.b  = x2;
        req.sh = 6'd30;
      end
      S_CDIV: begin
        req.op = OP_DIV;
        req.a  = tmp;
        req.b  = {56'd0, cos_div(n)};
      end
      S_S2: begin
        req.a  = {33'd0, s};
        req.b  = {33'd0, s};
        req.sh = 6'd30;
      end
      S_E0: begin
        req.op = OP_DIV;
        req.a  = {tmp[31:0], 32'd0};
        req.b  = {32'd0, ldiv};
      end
      S_E1: begin
        req.op = OP_DIV;
        req.a  = {tmp[60:0], 3'd0};
        req.b  = {32'd0, ldiv};
      end
      S_TMUL: begin
        req.a = t;
        req.b = {5'd0, e[63:5]};
      end
      S_TDIV: begin
        req.op = OP_DIV;
        req.a  = tmp;
        req.b  = {60'd0, n};
      end
      S_KSQ: begin
        req.a = {31'd0, k};
        req.b = {31'd0, k};
      end
      S_LMUL: begin
        req.a = {31'd0, k};
        req.b = e;
      end
      S_LDIV: begin
        req.op = OP_DIV;
        req.a  = {tmp[62:0], 1'b0};
        req.b  = {32'd0, ldiv};
      end
      S_PSC: begin
        req.a  = {33'd0, s};
        req.b  = {33'd0, c};
        req.sh = 6'd29;
      end
      S_PK: begin
        req.a  = {31'd0, k};
        req.b  = tmp;
        req.sh = 6'd30;
      end
      S_PD: begin
        req.a  = v;
        req.b  = {32'd0, d};
        req.sh = 6'd16;
      end
      S_PPI: begin
        req.a  = v;
        req.b  = PI_Q30;
        req.sh = 6'd29;
      end
      S_QHI: begin
        req.op = OP_DIV;
        req.a  = v;
        req.b  = {32'd0, qdiv};
      end
      S_QLO: begin
        req.op = OP_DIV;
        req.a  = {qrem[47:0], 16'd0};
        req.b  = {32'd0, qdiv};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issued       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_FIN);
      if (rsp.done) issued <= 1'b0;
      else if (req.valid) issued <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && go) begin
      sum_r  <= sum;
      ovf_r  <= ovf;
      gsel_r <= gsel;
      qsat   <= 1'b0;
    end
    if (state == S_FIN) begin
      kernel  <= 17'((k + 33'd32768) >> 16);
      grad    <= fin_grad[31:0];
      sat_out <= satg || ovf_r;
    end
    if (rsp.done) begin
      case (state)
        S_SQRT: d <= rsp.y[31:0];
        S_DMOD: tmp <= rsp.r;
        S_FRAC: begin
          f   <= rsp.y[31:0];
          tmp <= (rsp.y <= NEG_LIMIT) ? rsp.y : ONE_Q32 - rsp.y;
        end
        S_ANG: begin
          ts     <= rsp.y;
          as_acc <= $signed(rsp.y);
        end
        S_X2: begin
          x2     <= rsp.y;
          tc     <= ONE_Q30;
          ac_acc <= $signed(ONE_Q30);
          n      <= 4'd1;
        end
        S_SMUL, S_CMUL, S_S2, S_PSC, S_TMUL, S_LMUL: tmp <= rsp.y;
        S_SDIV: begin
          ts     <= rsp.y;
          as_acc <= as_n;
        end
        S_CDIV: begin
          tc     <= rsp.y;
          ac_acc <= ac_n;
          n      <= n + 4'd1;
          if (n == SC_TERMS) begin
            s <= clamp30(as_acc);
            c <= clamp30(ac_n);
          end
        end
        S_E0: begin
          if (rsp.y >= E_BIG) begin
            e <= EXP_LIMIT;
            k <= '0;
          end else begin
            tmp <= rsp.y;
          end
        end
        S_E1: begin
          e <= rsp.y;
          if (rsp.y >= EXP_LIMIT) k <= '0;
          t    <= ONE_Q32;
          eacc <= $signed(ONE_Q32);
          n    <= 4'd1;
        end
        S_TDIV: begin
          t    <= rsp.y;
          eacc <= eacc_n;
          n    <= n + 4'd1;
          if (n == EXP_TERMS) begin
            k <= clamp32(eacc_n);
            n <= 4'd0;
          end
        end
        S_KSQ: begin
          k <= rsp.y[32:0];
          n <= n + 4'd1;
        end
        S_LDIV, S_PK, S_PD: v <= rsp.y;
        S_PPI: begin
          v    <= rsp.y;
          qcnt <= 2'd0;
        end
        S_QHI: begin
          if (rsp.y[63:48] != 16'd0) qsat <= 1'b1;
          tmp  <= rsp.y;
          qrem <= rsp.r;
        end
        S_QLO: begin
          v    <= {tmp[47:0], 16'd0} + rsp.y;
          qcnt <= qcnt + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ design/periodic_kernel_with_gradient_top.sv @@
// Top level: element accumulator, configuration registers, sequencer and
// shared arithmetic unit. Depends on pkgrad_pkg, pkgrad_alu, pkgrad_seq.
`timescale 1ns / 1ps

// An element pair that is not the last one is taken when presented and busy
// stays low, so pairs may stream back to back. A pair marked last starts the
// finish, during which busy is high while the shared unit works in sequence
// through 18 to 39 divides, 18 to 39 multiplies and one square root; the
// result is then registered. The result appears on the result ports for one
// cycle with result_valid high and must be taken then; the receiver has no
// way to hold it off. Configuration writes are always taken (cfg_ready is
// high) and belong in idle time only.
module periodic_kernel_with_gradient_top
  import pkgrad_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ELEM_W-1:0] elem_a,
  input  logic signed [ELEM_W-1:0] elem_b,
  input  logic                     last_element,
  input  logic                     gradient_select,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [31:0]              cfg_data,
  output logic                     result_valid,
  output logic [16:0]              kernel_value,
  output logic signed [31:0]       gradient_value,
  output logic                     saturated
);

  logic [31:0]        lscale, period;
  logic [ACC_W-1:0]   sq_diff_sum;
  logic               sum_overflowed;
  logic               accept;
  logic signed [ELEM_W:0] diff;
  logic [ELEM_W:0]    mag;
  logic [2*ELEM_W+1:0] sq;
  logic [ACC_W:0]     sum_w;
  logic [ACC_W-1:0]   sum_sat;
  logic               over;
  logic [31:0]        grad;
  alu_req_t           req;
  alu_rsp_t           rsp;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    diff    = (ELEM_W+1)'(elem_a) - (ELEM_W+1)'(elem_b);
    mag     = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;
    sq      = mag * mag;
    sum_w   = (ACC_W+1)'(sq_diff_sum) + (ACC_W+1)'(sq);
    over    = sum_w[ACC_W];
    sum_sat = over ? '1 : sum_w[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lscale         <= ONE_Q32[47:16];
      period         <= ONE_Q32[47:16];
      sq_diff_sum    <= '0;
      sum_overflowed <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LENGTH: lscale <= cfg_data;
          CFG_PERIOD: period <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (last_element) begin
          sq_diff_sum    <= '0;
          sum_overflowed <= 1'b0;
        end else begin
          sq_diff_sum    <= sum_sat;
          sum_overflowed <= sum_overflowed || over;
        end
      end
    end
  end

  pkgrad_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .go           (accept && last_element),
    .sum          (sum_sat),
    .ovf          (sum_overflowed || over),
    .gsel         (gradient_select),
    .lsc          (lscale),
    .per          (period),
    .busy         (busy),
    .req          (req),
    .rsp          (rsp),
    .result_valid (result_valid),
    .kernel       (kernel_value),
    .grad         (grad),
    .sat_out      (saturated)
  );

  pkgrad_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign gradient_value = $signed(grad);

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for periodic_kernel_with_gradient_top: directed table plus random
// vectors, predicted in-bench. Depends on pkgrad_pkg and the top-level RTL.
`timescale 1ns / 1ps

module testbench;
  import pkgrad_pkg::*;

  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam bit [63:0] M32 = 64'hFFFF_FFFF;
  localparam bit [63:0] ACC_MAX = (64'd1 << ACC_W) - 1;

  typedef struct {
    bit [16:0] kv;
    bit [31:0] grad;
    bit        sat;
  } kern_res_t;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    bit                 last;
    bit                 gsel;
    bit                 typed;
    kern_res_t          want;
  } stim_row_t;

  logic clk = 0, rst = 1;
  logic start = 0, last_element = 0, gradient_select = 0;
  logic signed [ELEM_W-1:0] elem_a = 0, elem_b = 0;
  logic cfg_valid = 0, cfg_index = CFG_LENGTH;
  logic [31:0] cfg_data = 0;
  logic busy, cfg_ready, result_valid, saturated;
  logic [16:0] kernel_value;
  logic signed [31:0] gradient_value;

  periodic_kernel_with_gradient_top DUT (.*);

  always #5 clk = ~clk;

  // kernel model state
  bit [63:0] len_scale = 65536, per = 65536, sq_sum = 0;
  bit sum_ovf = 0;
  kern_res_t kernel_q[$];
  bit typed_pending = 0;
  kern_res_t typed_res;
  int errors = 0, idle_pct = 0;
  longint cycles = 0;

  task automatic report(string what, longint want, longint got);
    $display("mismatch %s: want %0h got %0h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  function automatic bit [63:0] mul_shr(bit [63:0] a, bit [63:0] b, int sh);
    bit [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic bit [63:0] div_q16(bit [63:0] x, bit [63:0] v, inout bit sat);
    bit [63:0] q, r;
    q = x / v;
    r = x % v;
    if (q >= (64'd1 << 48)) begin
      sat = 1;
      return '1;
    end
    return (q << 16) + ((r << 16) / v);
  endfunction

  function automatic bit [63:0] isqrt_q16(bit [63:0] sum);
    bit [63:0] root, rem, trial, hb, lb;
    int p;
    root = 0;
    rem = 0;
    for (int i = 39; i >= 0; i--) begin
      p = 2 * i;
      hb = (p + 1 >= 16) ? (sum >> (p + 1 - 16)) & 1 : 0;
      lb = (p >= 16) ? (sum >> (p - 16)) & 1 : 0;
      rem = (rem << 2) | (hb << 1) | lb;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic bit [63:0] clamp_hi(longint v, bit [63:0] hi);
    if (v < 0) return 0;
    if (64'(v) > hi) return hi;
    return 64'(v);
  endfunction

  function automatic void sin_cos(bit [63:0] x, output bit [63:0] s, output bit [63:0] c);
    bit [63:0] x2, ts, tc;
    longint as_, ac;
    x2 = (x * x) >> 30;
    ts = x;
    tc = ONE_Q30;
    as_ = longint'(x);
    ac = longint'(ONE_Q30);
    for (int n = 1; n <= 7; n++) begin
      ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2) begin
        as_ -= longint'(ts);
        ac -= longint'(tc);
      end else begin
        as_ += longint'(ts);
        ac += longint'(tc);
      end
    end
    s = clamp_hi(as_, ONE_Q30);
    c = clamp_hi(ac, ONE_Q30);
  endfunction

  // exp(-e) by a short series of exp(-e/32), then squared five times
  function automatic bit [63:0] exp_neg(bit [63:0] e);
    bit [63:0] y, t, k;
    longint acc;
    y = e >> 5;
    t = ONE_Q32;
    acc = longint'(ONE_Q32);
    for (int n = 1; n <= 13; n++) begin
      t = ((t * y) >> 32) / n;
      if (n % 2) acc -= longint'(t);
      else acc += longint'(t);
    end
    k = clamp_hi(acc, ONE_Q32);
    for (int n = 0; n < 5; n++) k = (k >= ONE_Q32) ? ONE_Q32 : ((k * k) >> 32);
    return k;
  endfunction

  function automatic kern_res_t kernel_finish(bit gsel);
    kern_res_t res;
    bit [63:0] l, p, d, f, g, x, s, c, s2, e, k, grad, sc2, big, sml, v;
    bit sat, neg;
    sat = 0;
    neg = 0;
    l = len_scale ? len_scale : 1;
    p = per ? per : 1;
    d = isqrt_q16(sq_sum);
    f = ((d % p) << 32) / p;
    g = (f <= NEG_LIMIT) ? f : ONE_Q32 - f;
    x = (g * PI_Q30) >> 32;
    sin_cos(x, s, c);
    s2 = (s * s) >> 30;
    e = (s2 << 32) / l;
    e = (e >= E_BIG) ? EXP_LIMIT : (e << 3) / l;
    k = (e >= EXP_LIMIT) ? 0 : exp_neg(e);
    if (!gsel) begin
      grad = (2 * mul_shr(k, e, 32)) / l;
    end else begin
      sc2 = (s * c) >> 29;
      big = (l > p) ? l : p;
      sml = (l > p) ? p : l;
      v = mul_shr(k, sc2, 30);
      v = mul_shr(v, d, 16);
      v = mul_shr(v, PI_Q30, 29);
      v = div_q16(v, big, sat);
      if (!sat) v = div_q16(v, big, sat);
      if (!sat) v = div_q16(v, sml, sat);
      if (!sat) v = div_q16(v, sml, sat);
      grad = sat ? '1 : (v >> 16);
      sat = 0;
      neg = (f > NEG_LIMIT) && grad != 0;
    end
    if (neg) begin
      if (grad > NEG_LIMIT) begin
        grad = NEG_LIMIT;
        sat = 1;
      end
      grad = (ONE_Q32 - grad) & M32;
    end else if (grad > POS_LIMIT) begin
      grad = POS_LIMIT;
      sat = 1;
    end
    res.kv = 17'((k + (1 << 15)) >> 16);
    res.grad = grad[31:0];
    res.sat = sat | sum_ovf;
    return res;
  endfunction

  // model update and result checking on each rising edge
  always @(posedge clk) begin
    longint diff;
    bit [63:0] mag, sq, sum;
    kern_res_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("periodic_kernel_with_gradient_top regression: fail");
      $finish;
    end else if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LENGTH) len_scale = cfg_data;
        else per = cfg_data;
      end
      if (start && !busy) begin
        diff = longint'(elem_a) - longint'(elem_b);
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        sq = mag * mag;
        sum = sq_sum + sq;
        if (sum > ACC_MAX) begin
          sum = ACC_MAX;
          sum_ovf = 1;
        end
        sq_sum = sum;
        if (last_element) begin
          kernel_q.push_back(typed_pending ? typed_res : kernel_finish(gradient_select));
          sq_sum = 0;
          sum_ovf = 0;
        end
      end
      if (result_valid) begin
        if (kernel_q.size() == 0) begin
          report("unexpected result", 0, kernel_value);
        end else begin
          want = kernel_q.pop_front();
          if (kernel_value !== want.kv) report("kernel_value", want.kv, kernel_value);
          if (gradient_value !== want.grad) report("gradient_value", want.grad, gradient_value);
          if (saturated !== want.sat) report("saturated", want.sat, saturated);
        end
      end
    end
  end

  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, bit last, bit gsel);
    while ($urandom_range(99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    elem_a = a;
    elem_b = b;
    last_element = last;
    gradient_select = gsel;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain();
    while (kernel_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return 32'hFFFF_FFFF;
      3: return 65536;
      4: return $urandom_range(32'h8_0000, 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vector(output int n);
    int len;
    bit narrow;
    logic signed [15:0] a, b;
    len = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(6, 1);
    narrow = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom);
      b = narrow ? a + 16'($signed($urandom_range(1024)) - 512) : 16'($urandom);
      send_pair(a, b, i == len - 1, 1'($urandom_range(1)));
    end
    n = len;
  endtask

  stim_row_t dir_rows[5];
  logic [31:0] dir_cfg[5][2] = '{'{65536, 65536}, '{0, 0}, '{1, 65536},
                                 '{32'h1000_0000, 1}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}};

  initial begin
    int sent, n;
    // zero distance gives kernel 1.0 and no gradient whatever the registers
    dir_rows[0] = '{16'sd0, 16'sd0, 1, 0, 1, '{17'd65536, 32'd0, 1'b0}};
    dir_rows[1] = '{-16'sd32768, -16'sd32768, 1, 1, 1, '{17'd65536, 32'd0, 1'b0}};
    dir_rows[2] = '{16'sd32767, -16'sd32768, 0, 0, 0, '{0, 0, 0}};
    dir_rows[3] = '{16'sh0080, 16'sd0, 1, 1, 0, '{0, 0, 0}};
    dir_rows[4] = '{-16'sd32768, 16'sd32767, 1, 0, 0, '{0, 0, 0}};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    @(negedge clk);

    foreach (dir_cfg[c]) begin
      drain();
      write_reg(CFG_LENGTH, dir_cfg[c][0]);
      write_reg(CFG_PERIOD, dir_cfg[c][1]);
      foreach (dir_rows[r]) begin
        typed_pending = dir_rows[r].typed;
        typed_res = dir_rows[r].want;
        send_pair(dir_rows[r].a, dir_rows[r].b, dir_rows[r].last, dir_rows[r].gsel);
        typed_pending = 0;
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 28 : (ph == 1) ? 45 : 0;
      sent = 0;
      while (sent < 310) begin
        if (sent % 80 < 8) begin
          drain();
          write_reg(CFG_LENGTH, pick_reg());
          write_reg(CFG_PERIOD, pick_reg());
        end
        if (ph == 0 && sent > 150 && sent < 160) drain();
        send_vector(n);
        sent += n;
      end
    end

    drain();
    repeat (2000) @(negedge clk);
    if (errors == 0 && kernel_q.size() == 0) begin
      $display("periodic_kernel_with_gradient_top regression: pass");
    end else begin
      $display("periodic_kernel_with_gradient_top regression: fail");
    end
    $finish;
  end

endmodule

@@ periodic_kernel_with_gradient_top.f @@
design/pkgrad_pkg.sv
design/pkgrad_alu.sv
design/pkgrad_seq.sv
design/periodic_kernel_with_gradient_top.sv
sim/testbench.sv
